/* sv/gbn_pkg.sv */
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared constants, codes and types of the Go-Back-N sender window core.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // Largest window that is honoured; wider settings saturate to it.
  localparam int MAX_WINDOW = 64;
  // Most result words that one input word may cause.
  localparam int RESULT_CAP = 64;

  // Field and register widths.
  localparam int CMD_W   = 2;
  localparam int ACK_W   = 32;
  localparam int KIND_W  = 2;
  localparam int PIDX_W  = 23;
  localparam int SEQ_W   = 32;
  localparam int WIN_W   = 7;
  localparam int CHUNK_W = 11;
  localparam int ISEQ_W  = 31;
  localparam int TICK_W  = 16;
  localparam int FSZ_W   = 31;
  localparam int IDX_W   = 31;
  localparam int K_W     = $clog2(RESULT_CAP + 1);
  localparam int PROD_W  = IDX_W + CHUNK_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int OUT_DATA_W = 88;

  // Divider geometry: one quotient bit per step.
  localparam int DIV_STEPS = ACK_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Input commands.
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_SEND     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RESEND   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITSEQ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FSIZE   = 3'd4;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_FS,
    S_MUL_BASE,
    S_CMP_BASE,
    S_DIV_ACK,
    S_LOOP,
    S_MUL,
    S_ADD,
    S_OUT,
    S_DONE_OUT
  } state_t;

  // Request to the iterative divider.
  typedef struct packed {
    logic               start;
    logic [ACK_W-1:0]   dividend;
    logic [CHUNK_W-1:0] divisor;
  } div_req_t;

  // Answer of the iterative divider.
  typedef struct packed {
    logic               done;
    logic [ACK_W-1:0]   quotient;
    logic [CHUNK_W-1:0] remainder;
  } div_rsp_t;

endpackage

/* sv/go_back_n_sender_window_core.sv */
// ----------------------------------------------------------------------------
// go_back_n_sender_window_core
// Send window of a Go-Back-N sender: start, acknowledgment and timer words in,
// send, resend and complete words out.
// ----------------------------------------------------------------------------
// One input word is taken at a time; in_tready is high only while the core is
// idle. Every start, acknowledgment and tick first divides the file size by the
// chunk size in a shared one-bit-per-cycle divider. An acknowledgment that
// slides the window costs a multiply and a second division. Each result word
// then passes through a multiply, a sequence add, an end add and load (which
// waits for a free output slot) and a window check. A finished result waits
// in the output register while the core goes on with the next word. Unused
// command 3 is dropped in the cycle it is taken.
module go_back_n_sender_window_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [gbn_pkg::ACK_W-1:0]          in_tdata,  // [31:0] ack_number
  input  logic [gbn_pkg::CMD_W-1:0]          in_tuser,  // [1:0] command
  // Result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [gbn_pkg::OUT_DATA_W-1:0]     out_tdata, // [22:0] packet_index,
                                                        // [54:23] start_seq,
                                                        // [86:55] end_seq,
                                                        // [87] zero
  output logic [gbn_pkg::KIND_W-1:0]         out_tuser, // [1:0] kind
  output logic                               out_tlast, // last_of_run
  // Configuration write port
  input  logic                               cfg_we,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gbn_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  gbn_pkg::state_t state_r, state_nxt;

  // Configuration registers
  logic [gbn_pkg::WIN_W-1:0]   window_r;
  logic [gbn_pkg::CHUNK_W-1:0] chunk_r;
  logic [gbn_pkg::ISEQ_W-1:0]  init_r;
  logic [gbn_pkg::TICK_W-1:0]  timeout_r;
  logic [gbn_pkg::FSZ_W-1:0]   fsize_r;

  // Window state
  logic [gbn_pkg::IDX_W-1:0]   base_r, base_nxt;
  logic [gbn_pkg::IDX_W-1:0]   next_r, next_nxt;
  logic [gbn_pkg::IDX_W-1:0]   total_r, total_nxt;
  logic [gbn_pkg::TICK_W-1:0]  tick_r, tick_nxt;
  logic                        timer_r, timer_nxt;

  // Per-word working registers
  logic [gbn_pkg::CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [gbn_pkg::ACK_W-1:0]   ack_r, ack_nxt;
  logic [gbn_pkg::K_W-1:0]     k_r, k_nxt;
  logic [gbn_pkg::KIND_W-1:0]  kind_r, kind_nxt;
  logic [gbn_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic                        last_r, last_nxt;
  logic [gbn_pkg::CHUNK_W-1:0] rem_r, rem_nxt;
  logic [gbn_pkg::CHUNK_W-1:0] len_r, len_nxt;
  logic [gbn_pkg::SUM_W-1:0]   start_r, start_nxt;
  logic [gbn_pkg::PROD_W-1:0]  prod_r;

  // Output register
  logic                          ovalid_r, ovalid_nxt;
  logic [gbn_pkg::OUT_DATA_W-1:0] odata_r, odata_nxt;
  logic [gbn_pkg::KIND_W-1:0]    okind_r, okind_nxt;
  logic                          olast_r, olast_nxt;

  gbn_pkg::div_req_t div_req;
  gbn_pkg::div_rsp_t div_rsp;

  logic                        in_acc;
  logic                        slot_free;
  logic [gbn_pkg::CHUNK_W-1:0] chunk_eff;
  logic [gbn_pkg::WIN_W-1:0]   win_eff;
  logic [gbn_pkg::IDX_W:0]     limit;
  logic [gbn_pkg::IDX_W:0]     next_inc;
  logic [gbn_pkg::IDX_W:0]     idx_inc;
  logic [gbn_pkg::K_W-1:0]     k_inc;
  logic                        send_ok, send_ok_nx;
  logic                        rsnd_ok, rsnd_ok_nx;
  logic                        loop_ok, loop_last;
  logic [gbn_pkg::TICK_W-1:0]  tick_inc;
  logic                        tick_hit;
  logic                        ack_in_file;
  logic [gbn_pkg::SUM_W-1:0]   seq_sum;
  logic                        ack_ge;
  logic [gbn_pkg::IDX_W+1:0]   new_base;
  logic [gbn_pkg::IDX_W-1:0]   mul_a;
  logic                        is_short;
  logic [gbn_pkg::SEQ_W-1:0]   end_seq;

  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !ovalid_r || out_tready;

  // Effective chunk and window.
  assign chunk_eff = (chunk_r == '0) ? gbn_pkg::CHUNK_W'(1) : chunk_r;
  always_comb begin
    if (window_r == '0) begin
      win_eff = gbn_pkg::WIN_W'(1);
    end else if (window_r > gbn_pkg::WIN_W'(gbn_pkg::MAX_WINDOW)) begin
      win_eff = gbn_pkg::WIN_W'(gbn_pkg::MAX_WINDOW);
    end else begin
      win_eff = window_r;
    end
  end

  // Window checks for this result and for the one after it.
  assign limit    = {1'b0, base_r} + {{(gbn_pkg::IDX_W + 1 - gbn_pkg::WIN_W){1'b0}}, win_eff};
  assign next_inc = {1'b0, next_r} + 1'b1;
  assign idx_inc  = {1'b0, idx_r} + 1'b1;
  assign k_inc    = k_r + 1'b1;

  assign send_ok    = ({1'b0, next_r} < limit) && (next_r < total_r)
                      && (k_r < gbn_pkg::K_W'(gbn_pkg::RESULT_CAP));
  assign send_ok_nx = (next_inc < limit) && (next_inc < {1'b0, total_r})
                      && (k_inc < gbn_pkg::K_W'(gbn_pkg::RESULT_CAP));
  assign rsnd_ok    = (idx_r < next_r) && (k_r < gbn_pkg::K_W'(gbn_pkg::RESULT_CAP));
  assign rsnd_ok_nx = (idx_inc < {1'b0, next_r})
                      && (k_inc < gbn_pkg::K_W'(gbn_pkg::RESULT_CAP));
  assign loop_ok    = (kind_r == gbn_pkg::KIND_SEND) ? send_ok : rsnd_ok;
  assign loop_last  = (kind_r == gbn_pkg::KIND_SEND) ? !send_ok_nx : !rsnd_ok_nx;

  // Saturating tick count and timeout test.
  assign tick_inc = (tick_r != {gbn_pkg::TICK_W{1'b1}}) ? tick_r + 1'b1 : tick_r;
  assign tick_hit = tick_inc >= timeout_r;

  // Acknowledgment against the end of the file and the start of base.
  assign ack_in_file = ack_r < ({1'b0, init_r} + {1'b0, fsize_r});
  assign seq_sum     = {{(gbn_pkg::SUM_W - gbn_pkg::ISEQ_W){1'b0}}, init_r}
                       + {1'b0, prod_r};
  assign ack_ge      = {{(gbn_pkg::SUM_W - gbn_pkg::ACK_W){1'b0}}, ack_r} >= seq_sum;
  assign new_base    = {2'b00, base_r} + {1'b0, div_rsp.quotient};

  // Shared multiplier, registered on every cycle.
  assign mul_a = (state_r == gbn_pkg::S_MUL_BASE) ? base_r : idx_r;
  always_ff @(posedge clk) begin
    prod_r <= mul_a * chunk_eff;
  end

  // The last packet of the file is short when the size is no multiple.
  assign is_short = (total_r != '0) && (idx_r == total_r - 1'b1) && (rem_r != '0);
  assign end_seq  = start_r[gbn_pkg::SEQ_W-1:0]
                    + {{(gbn_pkg::SEQ_W - gbn_pkg::CHUNK_W){1'b0}}, len_r}
                    - 1'b1;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gbn_pkg::S_IDLE: begin
        if (in_acc && (in_tuser == gbn_pkg::CMD_START || in_tuser == gbn_pkg::CMD_ACK
                       || in_tuser == gbn_pkg::CMD_TICK)) begin
          state_nxt = gbn_pkg::S_DIV_FS;
        end
      end
      gbn_pkg::S_DIV_FS: begin
        if (div_rsp.done) begin
          case (cmd_r)
            gbn_pkg::CMD_START: state_nxt = gbn_pkg::S_LOOP;
            gbn_pkg::CMD_ACK:   state_nxt = ack_in_file ? gbn_pkg::S_MUL_BASE
                                                        : gbn_pkg::S_DONE_OUT;
            default:            state_nxt = (timer_r && tick_hit) ? gbn_pkg::S_LOOP
                                                                  : gbn_pkg::S_IDLE;
          endcase
        end
      end
      gbn_pkg::S_MUL_BASE: state_nxt = gbn_pkg::S_CMP_BASE;
      gbn_pkg::S_CMP_BASE: state_nxt = ack_ge ? gbn_pkg::S_DIV_ACK : gbn_pkg::S_LOOP;
      gbn_pkg::S_DIV_ACK: begin
        if (div_rsp.done) begin
          state_nxt = gbn_pkg::S_LOOP;
        end
      end
      gbn_pkg::S_LOOP:     state_nxt = loop_ok ? gbn_pkg::S_MUL : gbn_pkg::S_IDLE;
      gbn_pkg::S_MUL:      state_nxt = gbn_pkg::S_ADD;
      gbn_pkg::S_ADD:      state_nxt = gbn_pkg::S_OUT;
      gbn_pkg::S_OUT: begin
        if (slot_free) begin
          state_nxt = gbn_pkg::S_LOOP;
        end
      end
      gbn_pkg::S_DONE_OUT: begin
        if (slot_free) begin
          state_nxt = gbn_pkg::S_IDLE;
        end
      end
      default: state_nxt = gbn_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs of each state.
  always_comb begin
    base_nxt   = base_r;
    next_nxt   = next_r;
    total_nxt  = total_r;
    tick_nxt   = tick_r;
    timer_nxt  = timer_r;
    cmd_nxt    = cmd_r;
    ack_nxt    = ack_r;
    k_nxt      = k_r;
    kind_nxt   = kind_r;
    idx_nxt    = idx_r;
    last_nxt   = last_r;
    rem_nxt    = rem_r;
    len_nxt    = len_r;
    start_nxt  = start_r;
    odata_nxt  = odata_r;
    okind_nxt  = okind_r;
    olast_nxt  = olast_r;
    ovalid_nxt = ovalid_r && !out_tready;
    in_tready  = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {1'b0, fsize_r};
    div_req.divisor  = chunk_eff;
    case (state_r)
      gbn_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          cmd_nxt = in_tuser;
          ack_nxt = in_tdata;
          k_nxt   = '0;
          div_req.start = (in_tuser == gbn_pkg::CMD_START || in_tuser == gbn_pkg::CMD_ACK
                           || in_tuser == gbn_pkg::CMD_TICK);
        end
      end
      gbn_pkg::S_DIV_FS: begin
        if (div_rsp.done) begin
          rem_nxt = div_rsp.remainder;
          case (cmd_r)
            gbn_pkg::CMD_START: begin
              total_nxt = div_rsp.quotient[gbn_pkg::IDX_W-1:0]
                          + {{(gbn_pkg::IDX_W - 1){1'b0}}, (div_rsp.remainder != '0)};
              base_nxt  = '0;
              next_nxt  = '0;
              tick_nxt  = '0;
              kind_nxt  = gbn_pkg::KIND_SEND;
            end
            gbn_pkg::CMD_ACK: begin
              tick_nxt = '0;
              kind_nxt = gbn_pkg::KIND_SEND;
            end
            default: begin
              if (timer_r) begin
                if (tick_hit) begin
                  tick_nxt = '0;
                  kind_nxt = gbn_pkg::KIND_RESEND;
                  idx_nxt  = base_r;
                end else begin
                  tick_nxt = tick_inc;
                end
              end
            end
          endcase
        end
      end
      gbn_pkg::S_CMP_BASE: begin
        div_req.start    = ack_ge;
        div_req.dividend = ack_r - seq_sum[gbn_pkg::ACK_W-1:0];
      end
      gbn_pkg::S_DIV_ACK: begin
        if (div_rsp.done) begin
          base_nxt = (new_base > {2'b00, next_r}) ? next_r
                                                  : new_base[gbn_pkg::IDX_W-1:0];
        end
      end
      gbn_pkg::S_LOOP: begin
        if (loop_ok) begin
          k_nxt    = k_inc;
          last_nxt = loop_last;
          if (kind_r == gbn_pkg::KIND_SEND) begin
            idx_nxt  = next_r;
            next_nxt = next_inc[gbn_pkg::IDX_W-1:0];
          end
        end else if (kind_r == gbn_pkg::KIND_SEND) begin
          timer_nxt = next_r > base_r;
        end
      end
      gbn_pkg::S_ADD: begin
        start_nxt = seq_sum;
        len_nxt   = is_short ? rem_r : chunk_eff;
      end
      gbn_pkg::S_OUT: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = kind_r;
          olast_nxt  = last_r;
          odata_nxt  = {1'b0, end_seq, start_r[gbn_pkg::SEQ_W-1:0],
                        idx_r[gbn_pkg::PIDX_W-1:0]};
          if (kind_r == gbn_pkg::KIND_RESEND) begin
            idx_nxt = idx_inc[gbn_pkg::IDX_W-1:0];
          end
        end
      end
      gbn_pkg::S_DONE_OUT: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = gbn_pkg::KIND_COMPLETE;
          olast_nxt  = 1'b1;
          odata_nxt  = '0;
          timer_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control and window registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= gbn_pkg::S_IDLE;
      base_r   <= '0;
      next_r   <= '0;
      total_r  <= '0;
      tick_r   <= '0;
      timer_r  <= 1'b0;
      k_r      <= '0;
      kind_r   <= gbn_pkg::KIND_SEND;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      base_r   <= base_nxt;
      next_r   <= next_nxt;
      total_r  <= total_nxt;
      tick_r   <= tick_nxt;
      timer_r  <= timer_nxt;
      k_r      <= k_nxt;
      kind_r   <= kind_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    ack_r   <= ack_nxt;
    idx_r   <= idx_nxt;
    last_r  <= last_nxt;
    rem_r   <= rem_nxt;
    len_r   <= len_nxt;
    start_r <= start_nxt;
    odata_r <= odata_nxt;
    okind_r <= okind_nxt;
    olast_r <= olast_nxt;
  end

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= gbn_pkg::WIN_W'(1);
      chunk_r   <= gbn_pkg::CHUNK_W'(512);
      init_r    <= '0;
      timeout_r <= gbn_pkg::TICK_W'(8);
      fsize_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gbn_pkg::REG_WINDOW:  window_r  <= cfg_wdata[gbn_pkg::WIN_W-1:0];
        gbn_pkg::REG_CHUNK:   chunk_r   <= cfg_wdata[gbn_pkg::CHUNK_W-1:0];
        gbn_pkg::REG_INITSEQ: init_r    <= cfg_wdata[gbn_pkg::ISEQ_W-1:0];
        gbn_pkg::REG_TIMEOUT: timeout_r <= cfg_wdata[gbn_pkg::TICK_W-1:0];
        gbn_pkg::REG_FSIZE:   fsize_r   <= cfg_wdata[gbn_pkg::FSZ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Shared divider.
  gbn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

`ifndef NO_ASSERTIONS
  // The window never runs past its own next index.
  a_base_le_next: assert property (@(posedge clk) disable iff (!rst_n)
    base_r <= next_r)
    else $error("base index beyond next index");

  // Sends never go beyond the packet count of the transfer.
  a_next_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    next_r <= total_r)
    else $error("next index beyond packet total");

  // Between words the timer runs only with packets outstanding.
  a_timer_outstanding: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gbn_pkg::S_IDLE && timer_r) |-> (next_r > base_r))
    else $error("timer running with nothing outstanding");

  // A quotient arrives only while the sequencer waits for one.
  a_div_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == gbn_pkg::S_DIV_FS || state_r == gbn_pkg::S_DIV_ACK))
    else $error("unexpected divider result");
`endif

endmodule

/* sv/gbn_div.sv */
// ----------------------------------------------------------------------------
// gbn_div
// Restoring divider: one quotient bit per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
module gbn_div (
  input  logic              clk,
  input  logic              rst_n,
  input  gbn_pkg::div_req_t req,
  output gbn_pkg::div_rsp_t rsp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [gbn_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [gbn_pkg::ACK_W-1:0]     quo_r, quo_nxt;
  logic [gbn_pkg::CHUNK_W-1:0]   rem_r, rem_nxt;
  logic [gbn_pkg::CHUNK_W-1:0]   dvs_r, dvs_nxt;
  logic [gbn_pkg::CHUNK_W:0]     shifted;
  logic [gbn_pkg::CHUNK_W:0]     diff;
  logic                          fits;

  // Trial subtraction of one step.
  assign shifted = {rem_r, quo_r[gbn_pkg::ACK_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  // Step control and datapath.
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = gbn_pkg::DIV_CNT_W'(gbn_pkg::DIV_STEPS);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[gbn_pkg::CHUNK_W-1:0] : shifted[gbn_pkg::CHUNK_W-1:0];
      quo_nxt = {quo_r[gbn_pkg::ACK_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == gbn_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand registers.
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule
